// ----- rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

   localparam int TCW_COLUMNS = 80;
   localparam int TCW_ROWS    = 25;

   localparam int MODE_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int COL_OUT_W   = 7;
   localparam int ROW_OUT_W   = 5;
   localparam int WORD_W      = 16;
   localparam int COLOUR_W    = 4;
   localparam int CSR_IDX_W   = 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT   = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_READ  = 2'd2
   } tcw_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_COLOUR = 1'b0,
      CSR_BACK_COLOUR = 1'b1
   } tcw_csr_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PUT,
      S_COPY,
      S_BLANK,
      S_CLEAR,
      S_READ,
      S_DONE
   } tcw_state_type;

   localparam logic [CHAR_W-1:0]   CHAR_BS     = 8'h08;
   localparam logic [CHAR_W-1:0]   CHAR_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0]   CHAR_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0]   BLANK_GLYPH = 8'h20;

   localparam logic [COLOUR_W-1:0] TEXT_COLOUR_RESET = 4'd2;
   localparam logic [COLOUR_W-1:0] BACK_COLOUR_RESET = 4'd0;

endpackage

`default_nettype wire

// ----- rtl/tcw_req_if.sv -----
`default_nettype none

interface tcw_req_if;
   logic                             valid;
   logic                             ready;
   logic [tcw_pkg::MODE_W-1:0]       mode;
   logic [tcw_pkg::CHAR_W-1:0]       char_code;
   logic [tcw_pkg::INDEX_W-1:0]      cell_index;

   modport source (output valid, output mode, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input mode, input char_code, input cell_index,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_rsp_if.sv -----
`default_nettype none

interface tcw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tcw_pkg::COL_OUT_W-1:0]    cursor_col;
   logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row;
   logic [tcw_pkg::WORD_W-1:0]       cell_word;
   logic                             did_scroll;

   modport source (output valid, output cursor_col, output cursor_row, output cell_word,
                   output did_scroll, input ready);
   modport sink   (input valid, input cursor_col, input cursor_row, input cell_word,
                   input did_scroll, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = tcw_pkg::WORD_W,
   parameter int DEPTH = tcw_pkg::TCW_COLUMNS * tcw_pkg::TCW_ROWS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/text_console_writer_core.sv -----
`default_nettype none

// Put, read and the other modes go from S_IDLE through S_PUT, S_READ or S_DONE to the
// registered result. Clear sweeps all cells in S_CLEAR; a scroll adds S_COPY and S_BLANK passes to a put.
// The sweeps run through the single write port of the screen RAM, one cell a cycle.
// One item in flight at a time; req_chan.ready is high only in S_IDLE, and a busy output holds the core in S_DONE.
// Reset: synchronous; afterwards a clearing pass in S_INIT zeroes every cell of the
// screen RAM and req_chan.ready stays low until it ends. Colours reset to 2 and 0.

module text_console_writer_core #(
   parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
   parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tcw_req_if.sink                            req_chan,
   tcw_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcw_pkg::COLOUR_W-1:0]  csr_wdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int COPY  = CELLS - COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(CELLS + 1);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   tcw_pkg::tcw_state_type state_ff, state_in;

   logic [CW-1:0]                    col_ff, col_in;
   logic [RW-1:0]                    row_ff, row_in;
   logic [SW-1:0]                    sweep_ff, sweep_in;
   logic [tcw_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [tcw_pkg::CHAR_W-1:0]       char_ff, char_in;
   logic [tcw_pkg::WORD_W-1:0]       word_ff, word_in;
   logic                             scroll_ff, scroll_in;
   logic [tcw_pkg::COLOUR_W-1:0]     text_ff, text_in;
   logic [tcw_pkg::COLOUR_W-1:0]     back_ff, back_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::COL_OUT_W-1:0]    rsp_col_ff;
   logic [tcw_pkg::ROW_OUT_W-1:0]    rsp_row_ff;
   logic [tcw_pkg::WORD_W-1:0]       rsp_word_ff;
   logic                             rsp_scroll_ff;

   logic                             req_ready;
   logic                             fin;
   logic                             out_free;
   logic                             load;

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [tcw_pkg::WORD_W-1:0]       wr_data;
   logic [AW-1:0]                    rd_addr;
   logic [tcw_pkg::WORD_W-1:0]       rd_data;

   logic [CW:0]                      col_t;
   logic [RW:0]                      row_t;
   logic [CW-1:0]                    pos_col;
   logic [RW-1:0]                    pos_row;
   logic [tcw_pkg::CHAR_W-1:0]       glyph;
   logic [tcw_pkg::CHAR_W-1:0]       attr;
   logic [SW-1:0]                    sweep_src;
   logic [SW-1:0]                    sweep_dst;

   assign attr      = {back_ff, text_ff};
   assign sweep_src = sweep_ff + SW'(COLUMNS);
   assign sweep_dst = sweep_ff - SW'(1);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   tcw_ram #(
      .WIDTH (tcw_pkg::WORD_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      sweep_in  = sweep_ff;
      mode_in   = mode_ff;
      char_in   = char_ff;
      word_in   = word_ff;
      scroll_in = scroll_ff;
      req_ready = 1'b0;
      fin       = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;
      col_t     = {1'b0, col_ff};
      row_t     = {1'b0, row_ff};
      pos_col   = col_ff;
      pos_row   = row_ff;
      glyph     = char_ff;

      case (state_ff)
         tcw_pkg::S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff[AW-1:0];
            sweep_in = sweep_ff + SW'(1);
            if (sweep_ff == SW'(CELLS - 1)) begin
               state_in = tcw_pkg::S_IDLE;
            end
         end
         tcw_pkg::S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = AW'(req_chan.cell_index);
            if (req_chan.valid) begin
               mode_in   = req_chan.mode;
               char_in   = req_chan.char_code;
               word_in   = '0;
               scroll_in = 1'b0;
               sweep_in  = '0;
               case (req_chan.mode)
                  tcw_pkg::MODE_PUT: begin
                     state_in = tcw_pkg::S_PUT;
                  end
                  tcw_pkg::MODE_CLEAR: begin
                     state_in = tcw_pkg::S_CLEAR;
                  end
                  tcw_pkg::MODE_READ: begin
                     if (32'(req_chan.cell_index) < 32'(CELLS)) begin
                        state_in = tcw_pkg::S_READ;
                     end else begin
                        state_in = tcw_pkg::S_DONE;
                     end
                  end
                  default: begin
                     state_in = tcw_pkg::S_DONE;
                  end
               endcase
            end
         end
         tcw_pkg::S_PUT: begin
            if (char_ff == tcw_pkg::CHAR_CR) begin
               col_t = '0;
            end else if (char_ff == tcw_pkg::CHAR_LF) begin
               col_t = '0;
               row_t = row_t + (RW+1)'(1);
            end else if (char_ff == tcw_pkg::CHAR_BS) begin
               if (col_ff != '0) begin
                  col_t = col_t - (CW+1)'(1);
               end else if (row_ff != '0) begin
                  row_t = row_t - (RW+1)'(1);
                  col_t = (CW+1)'(COLUMNS - 1);
               end
               pos_col = col_t[CW-1:0];
               pos_row = row_t[RW-1:0];
               glyph   = tcw_pkg::BLANK_GLYPH;
               wr_en   = 1'b1;
            end else if (char_ff >= tcw_pkg::BLANK_GLYPH) begin
               wr_en = 1'b1;
               col_t = col_t + (CW+1)'(1);
            end
            wr_addr = AW'(pos_row) * AW'(COLUMNS) + AW'(pos_col);
            wr_data = {attr, glyph};
            if (col_t == (CW+1)'(COLUMNS)) begin
               col_t = '0;
               row_t = row_t + (RW+1)'(1);
            end
            if (row_t == (RW+1)'(ROWS)) begin
               row_t     = (RW+1)'(ROWS - 1);
               scroll_in = 1'b1;
               sweep_in  = '0;
               state_in  = tcw_pkg::S_COPY;
            end else begin
               fin = 1'b1;
            end
            col_in = col_t[CW-1:0];
            row_in = row_t[RW-1:0];
         end
         tcw_pkg::S_COPY: begin
            rd_addr = sweep_src[AW-1:0];
            if (sweep_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = sweep_dst[AW-1:0];
               wr_data = rd_data;
            end
            if (sweep_ff == SW'(COPY)) begin
               state_in = tcw_pkg::S_BLANK;
            end else begin
               sweep_in = sweep_ff + SW'(1);
            end
         end
         tcw_pkg::S_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff[AW-1:0];
            wr_data = {attr, tcw_pkg::BLANK_GLYPH};
            if (sweep_ff == SW'(CELLS - 1)) begin
               fin = 1'b1;
            end else begin
               sweep_in = sweep_ff + SW'(1);
            end
         end
         tcw_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff[AW-1:0];
            wr_data = {attr, tcw_pkg::BLANK_GLYPH};
            if (sweep_ff == SW'(CELLS - 1)) begin
               col_in = '0;
               row_in = '0;
               fin    = 1'b1;
            end else begin
               sweep_in = sweep_ff + SW'(1);
            end
         end
         tcw_pkg::S_READ: begin
            word_in = rd_data;
            fin     = 1'b1;
         end
         tcw_pkg::S_DONE: begin
            fin = 1'b1;
         end
         default: begin
            state_in = tcw_pkg::S_IDLE;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            state_in = tcw_pkg::S_IDLE;
         end else begin
            state_in = tcw_pkg::S_DONE;
         end
      end
   end

   assign load = fin && out_free;

   always_comb begin
      text_in = text_ff;
      back_in = back_ff;
      if (csr_we) begin
         case (csr_index)
            tcw_pkg::CSR_TEXT_COLOUR: text_in = csr_wdata;
            tcw_pkg::CSR_BACK_COLOUR: back_in = csr_wdata;
            default: begin
               text_in = text_ff;
               back_in = back_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::S_INIT;
         sweep_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         text_ff      <= tcw_pkg::TEXT_COLOUR_RESET;
         back_ff      <= tcw_pkg::BACK_COLOUR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         text_ff      <= text_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      char_ff   <= char_in;
      word_ff   <= word_in;
      scroll_ff <= scroll_in;
      if (load) begin
         rsp_col_ff    <= tcw_pkg::COL_OUT_W'(col_in);
         rsp_row_ff    <= tcw_pkg::ROW_OUT_W'(row_in);
         rsp_word_ff   <= word_in;
         rsp_scroll_ff <= scroll_in;
      end
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_col = rsp_col_ff;
   assign rsp_chan.cursor_row = rsp_row_ff;
   assign rsp_chan.cell_word  = rsp_word_ff;
   assign rsp_chan.did_scroll = rsp_scroll_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor outside the screen");

   a_scroll_only_on_put: assert property (@(posedge clock) disable iff (reset)
      (load && scroll_in) |-> (mode_ff == tcw_pkg::MODE_PUT))
      else $error("scroll reported for a non-put beat");

   a_no_result_during_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::S_INIT) |-> !rsp_valid_ff)
      else $error("result beat during clearing pass");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != tcw_pkg::S_IDLE))
      else $error("accepted beat did not start work");

endmodule

`default_nettype wire

// ----- dv/text_console_writer_core_test.sv -----
`timescale 1ns / 1ps

module text_console_writer_core_test;

   localparam int COLS         = tcw_pkg::TCW_COLUMNS;
   localparam int LINES        = tcw_pkg::TCW_ROWS;
   localparam int CELL_TOTAL   = COLS * LINES;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS  = 184;
   localparam int REPORT_LIMIT = 10;
   localparam logic [tcw_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [tcw_pkg::COL_OUT_W-1:0] col;
      logic [tcw_pkg::ROW_OUT_W-1:0] row;
      logic [tcw_pkg::WORD_W-1:0]    word;
      logic                          scroll;
   } console_report_type;

   typedef struct {
      logic [tcw_pkg::MODE_W-1:0]  mode;
      logic [tcw_pkg::CHAR_W-1:0]  ch;
      logic [tcw_pkg::INDEX_W-1:0] idx;
      bit                          fixed;
      console_report_type          want;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [tcw_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tcw_pkg::COLOUR_W-1:0]  csr_wdata;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();

   text_console_writer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   logic [tcw_pkg::WORD_W-1:0]   screen_image [CELL_TOTAL];
   int                           cur_col;
   int                           cur_row;
   logic [tcw_pkg::COLOUR_W-1:0] fg_colour;
   logic [tcw_pkg::COLOUR_W-1:0] bg_colour;
   console_report_type           pending_reports [$];
   int                           send_idle;
   int                           recv_idle;
   int                           fail_count = 0;

   function automatic logic [tcw_pkg::WORD_W-1:0] cell_of(
         input logic [tcw_pkg::CHAR_W-1:0] glyph);
      return {bg_colour, fg_colour, glyph};
   endfunction

   function automatic console_report_type apply_request(
         input logic [tcw_pkg::MODE_W-1:0] op,
         input logic [tcw_pkg::CHAR_W-1:0] ch,
         input logic [tcw_pkg::INDEX_W-1:0] idx);
      console_report_type rep;
      int spot;
      rep = '0;
      if (op == tcw_pkg::MODE_PUT) begin
         if (ch == tcw_pkg::CHAR_CR) begin
            cur_col = 0;
         end else if (ch == tcw_pkg::CHAR_LF) begin
            cur_col = 0;
            cur_row++;
         end else if (ch == tcw_pkg::CHAR_BS) begin
            spot = cur_row * COLS + cur_col;
            if (spot > 0) spot--;
            if (cur_col > 0) begin
               cur_col--;
            end else if (cur_row > 0) begin
               cur_row--;
               cur_col = COLS - 1;
            end
            screen_image[spot] = cell_of(tcw_pkg::BLANK_GLYPH);
         end else if (ch >= tcw_pkg::BLANK_GLYPH) begin
            screen_image[cur_row * COLS + cur_col] = cell_of(ch);
            cur_col++;
         end
         if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
         end
         if (cur_row >= LINES) begin
            for (int i = 0; i < CELL_TOTAL - COLS; i++) screen_image[i] = screen_image[i + COLS];
            for (int i = CELL_TOTAL - COLS; i < CELL_TOTAL; i++)
               screen_image[i] = cell_of(tcw_pkg::BLANK_GLYPH);
            cur_row = LINES - 1;
            rep.scroll = 1'b1;
         end
      end else if (op == tcw_pkg::MODE_CLEAR) begin
         for (int i = 0; i < CELL_TOTAL; i++) screen_image[i] = cell_of(tcw_pkg::BLANK_GLYPH);
         cur_col = 0;
         cur_row = 0;
      end else if (op == tcw_pkg::MODE_READ && idx < CELL_TOTAL) begin
         rep.word = screen_image[idx];
      end
      rep.col = tcw_pkg::COL_OUT_W'(cur_col);
      rep.row = tcw_pkg::ROW_OUT_W'(cur_row);
      return rep;
   endfunction

   task automatic send_item(input logic [tcw_pkg::MODE_W-1:0] op,
                            input logic [tcw_pkg::CHAR_W-1:0] ch,
                            input logic [tcw_pkg::INDEX_W-1:0] idx, input bit fixed,
                            input console_report_type want);
      console_report_type rep;
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= op;
      req_chan.char_code  <= ch;
      req_chan.cell_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      rep = apply_request(op, ch, idx);
      pending_reports.push_back(fixed ? want : rep);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colours(input logic [tcw_pkg::COLOUR_W-1:0] text,
                                input logic [tcw_pkg::COLOUR_W-1:0] back);
      csr_we    <= 1'b1;
      csr_index <= tcw_pkg::CSR_TEXT_COLOUR;
      csr_wdata <= text;
      @(posedge clock);
      fg_colour = text;
      csr_index <= tcw_pkg::CSR_BACK_COLOUR;
      csr_wdata <= back;
      @(posedge clock);
      bg_colour = back;
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      console_report_type got;
      console_report_type want;
      if (rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.cursor_col, rsp_chan.cursor_row, rsp_chan.cell_word,
                rsp_chan.did_scroll};
         if (pending_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t unexpected beat: col=%0d row=%0d word=%h scroll=%b",
                        $realtime, got.col, got.row, got.word, got.scroll);
         end else begin
            want = pending_reports.pop_front();
            if (got.col !== want.col || got.row !== want.row ||
                got.word !== want.word || got.scroll !== want.scroll) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"%0t mismatch: exp col=%0d row=%0d word=%h scroll=%b, ",
                            "got col=%0d row=%0d word=%h scroll=%b"},
                           $realtime, want.col, want.row, want.word, want.scroll,
                           got.col, got.row, got.word, got.scroll);
            end
         end
      end
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #50_000_000;
      $display("FAIL text_console_writer_core");
      $finish;
   end

   initial begin
      directed_row_type rows [DIRECTED_COUNT];
      logic [tcw_pkg::MODE_W-1:0]  op;
      logic [tcw_pkg::CHAR_W-1:0]  ch;
      logic [tcw_pkg::INDEX_W-1:0] idx;
      int r;
      int base;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = tcw_pkg::MODE_PUT;
      req_chan.char_code  = '0;
      req_chan.cell_index = '0;
      csr_we              = 1'b0;
      csr_index           = tcw_pkg::CSR_TEXT_COLOUR;
      csr_wdata           = '0;
      send_idle           = 6;
      recv_idle           = 58;

      for (int i = 0; i < CELL_TOTAL; i++) screen_image[i] = '0;
      cur_col   = 0;
      cur_row   = 0;
      fg_colour = tcw_pkg::TEXT_COLOUR_RESET;
      bg_colour = tcw_pkg::BACK_COLOUR_RESET;

      rows = '{
         '{tcw_pkg::MODE_READ,  8'h00,   11'd0,    1'b1, '{7'd0,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'h00,   11'd1999, 1'b1, '{7'd0,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'hFF,   11'd2047, 1'b1, '{7'd0,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   tcw_pkg::CHAR_BS, 11'd0, 1'b1,
           '{7'd0,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'h00,   11'd0,    1'b1, '{7'd0,  5'd0, 16'h0220, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h41,   11'd2047, 1'b1, '{7'd1,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'hFF,   11'd0,    1'b1, '{7'd2,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h7F,   11'd0,    1'b1, '{7'd3,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h20,   11'd0,    1'b1, '{7'd4,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h80,   11'd0,    1'b1, '{7'd5,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'h00,   11'd1,    1'b1, '{7'd5,  5'd0, 16'h02FF, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h00,   11'd0,    1'b1, '{7'd5,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h1F,   11'd0,    1'b1, '{7'd5,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   tcw_pkg::CHAR_CR, 11'd0, 1'b1,
           '{7'd0,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   tcw_pkg::CHAR_LF, 11'd0, 1'b1,
           '{7'd0,  5'd1, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   tcw_pkg::CHAR_BS, 11'd0, 1'b1,
           '{7'd79, 5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h5A,   11'd0,    1'b1, '{7'd0,  5'd1, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   8'h71,   11'd0,    1'b1, '{7'd1,  5'd1, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_PUT,   tcw_pkg::CHAR_BS, 11'd0, 1'b1,
           '{7'd0,  5'd1, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'h00,   11'd80,   1'b1, '{7'd0,  5'd1, 16'h0220, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'h00,   11'd79,   1'b1, '{7'd0,  5'd1, 16'h025A, 1'b0}},
         '{MODE_SPARE,          8'hFF,   11'd2047, 1'b1, '{7'd0,  5'd1, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_CLEAR, 8'h00,   11'd0,    1'b1, '{7'd0,  5'd0, 16'h0000, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'h00,   11'd1999, 1'b1, '{7'd0,  5'd0, 16'h0220, 1'b0}},
         '{tcw_pkg::MODE_READ,  8'h00,   11'd4,    1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED_COUNT; k++)
         send_item(rows[k].mode, rows[k].ch, rows[k].idx, rows[k].fixed, rows[k].want);

      for (int phase = 0; phase < 3; phase++) begin
         drain();
         case (phase)
            0: write_colours(4'hF, 4'hF);
            1: write_colours(4'h0, 4'h0);
            default: write_colours(tcw_pkg::COLOUR_W'($urandom_range(14, 1)),
                                   tcw_pkg::COLOUR_W'($urandom_range(14, 1)));
         endcase
         case (phase)
            0: begin
               send_idle = 6;
               recv_idle = 58;
            end
            1: begin
               send_idle = 58;
               recv_idle = 6;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op  = tcw_pkg::MODE_PUT;
            ch  = tcw_pkg::CHAR_W'($urandom_range(255));
            idx = tcw_pkg::INDEX_W'($urandom_range(2047));
            r   = int'($urandom_range(99));
            if (r < 45) begin
               ch = tcw_pkg::CHAR_W'($urandom_range(255, 32));
            end else if (r < 65) begin
               ch = tcw_pkg::CHAR_LF;
            end else if (r < 69) begin
               ch = tcw_pkg::CHAR_CR;
            end else if (r < 77) begin
               ch = tcw_pkg::CHAR_BS;
            end else if (r < 80) begin
               ch = tcw_pkg::CHAR_W'($urandom_range(31));
            end else if (r < 95) begin
               op = tcw_pkg::MODE_READ;
               if ($urandom_range(3) != 0) begin
                  base = cur_row * COLS + cur_col;
                  idx  = tcw_pkg::INDEX_W'(base -
                                           int'($urandom_range(base < 240 ? base : 240)));
               end
            end else if (r < 97) begin
               op = MODE_SPARE;
            end else begin
               op = tcw_pkg::MODE_W'($urandom_range(3));
            end
            send_item(op, ch, idx, 1'b0, '0);
         end
      end

      drain();
      if (fail_count == 0)
         $display("PASS text_console_writer_core");
      else
         $display("FAIL text_console_writer_core");
      $finish;
   end

endmodule
